@@ hw/rtl/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg: shared constants and types
// Digit widths, ASCII codes and the pipeline word type of the converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned MagW    = 32;
  localparam int unsigned NDigits = 10;
  localparam int unsigned BcdW    = 4 * NDigits;
  localparam int unsigned NStages = 4;
  localparam int unsigned BitsPerStage = MagW / NStages;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
    logic [BcdW-1:0] bcd;
  } dd_word_t;

  // One shift-add step: add 3 to every digit of 5 or more, then shift in a bit.
  function automatic logic [BcdW-1:0] dd_step(logic [BcdW-1:0] bcd, logic bit_in);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int k = 0; k < NDigits; k++) begin
      if (adj[4*k +: 4] >= 4'd5) adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

endpackage

@@ hw/rtl/sitda_dd_stage.sv @@
// ----------------------------------------------------------------------------
// sitda_dd_stage: one double-dabble pipeline stage
// Runs a fixed slice of shift-add steps on one word, with a stall-safe register.
// ----------------------------------------------------------------------------
module sitda_dd_stage import sitda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  dd_word_t word_i,
  output logic     valid_o,
  input  logic     ready_i,
  output dd_word_t word_o
);

  logic     valid_q;
  dd_word_t word_q, word_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    word_d = word_i;
    for (int s = 0; s < BitsPerStage; s++) begin
      word_d.bcd = dd_step(word_d.bcd, word_d.mag[MagW-1]);
      word_d.mag = {word_d.mag[MagW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) word_q <= word_d;
  end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII
// Four-stage double-dabble pipeline followed by a character serialiser.
// ----------------------------------------------------------------------------
// A word enters every cycle while the pipeline has room; each number passes
// through the four double-dabble stages (eight shift-add steps each) and
// then leaves as one to eleven characters, one per cycle while m_axis_tready
// is high, most significant first, with tlast on the final one. Sustained
// rate is set by the output serialiser: one character per cycle, unless stalled.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tlast    // last_char
);

  dd_word_t w [NStages+1];
  logic     v [NStages+1];
  logic     r [NStages+1];

  always_comb begin
    w[0].neg = s_axis_tdata[31];
    w[0].mag = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
    w[0].bcd = '0;
  end
  assign v[0]          = s_axis_tvalid;
  assign s_axis_tready = r[0];

  for (genvar g = 0; g < NStages; g++) begin : g_st
    sitda_dd_stage u_st (
      .clk_i, .rst_ni,
      .valid_i(v[g]), .ready_o(r[g]), .word_i(w[g]),
      .valid_o(v[g+1]), .ready_i(r[g+1]), .word_o(w[g+1])
    );
  end

  // Serialiser: holds one converted number and emits it character by character.
  logic            busy_q;
  logic            sign_q;
  logic [BcdW-1:0] bcd_q;
  logic [3:0]      idx_q;    // digit index being emitted, most significant first
  logic [3:0]      top;
  logic            fire, done;

  always_comb begin
    top = 4'd0;
    for (int k = 0; k < NDigits; k++) begin
      if (w[NStages].bcd[4*k +: 4] != 4'd0) top = 4'(k);
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = sign_q ? CharMinus : (CharZero + {4'd0, bcd_q[{idx_q, 2'b00} +: 4]});
  assign m_axis_tlast  = !sign_q && (idx_q == 4'd0);
  assign fire          = busy_q && m_axis_tready;
  assign done          = fire && m_axis_tlast;
  assign r[NStages]    = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (r[NStages]) begin
      busy_q <= v[NStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r[NStages] && v[NStages]) begin
      sign_q <= w[NStages].neg;
      bcd_q  <= w[NStages].bcd;
      idx_q  <= top;
    end else if (fire) begin
      if (sign_q) sign_q <= 1'b0;
      else        idx_q  <= idx_q - 4'd1;
    end
  end

endmodule

@@ hw/rtl/sitda_checker.sv @@
// ----------------------------------------------------------------------------
// sitda_checker: port-level checks for the converter
// Watches output characters and handshakes over time.
// ----------------------------------------------------------------------------
module sitda_checker import sitda_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A character is a minus sign or a digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == CharMinus) ||
      (m_axis_tdata >= CharZero && m_axis_tdata <= CharZero + 8'd9))
    else $error("bad character");

  // The minus sign is never last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == CharMinus |-> !m_axis_tlast)
    else $error("minus sign marked last");

  // A stalled word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  // Minus is followed by a non-zero leading digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata == CharMinus |=>
      !m_axis_tvalid || m_axis_tdata != CharZero)
    else $error("leading zero after minus");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
